// ===== design/arp_rrt_pkg.sv =====
// Shared constants, codes and helper functions for the ARP reply responder tracker.
package arp_rrt_pkg;

	localparam int TABLE_ENTRIES = 5;
	localparam int COUNT_BITS    = 16;

	localparam int MAC_W   = 48;
	localparam int IP_W    = 32;
	localparam int OP_W    = 16;
	localparam int PCNT_W  = 16;
	localparam int PIDX_W  = 3;
	localparam int EXT_W   = (COUNT_BITS > PCNT_W) ? COUNT_BITS : PCNT_W;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = MAC_W;

	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 120;

	// request kinds (tuser)
	localparam logic REQ_OBSERVE = 1'b0;
	localparam logic REQ_CLEAR   = 1'b1;

	localparam logic [OP_W-1:0] OPCODE_REPLY = 16'd2;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_LOCAL_IP     = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_PROBE_IP     = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_ATTACKER_MAC = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [MAC_W-1:0]      mac_t;

	// entry count as shown on the result, saturated to the field width
	function automatic logic [PCNT_W-1:0] show_count(input count_t c);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(c);
		if (ext > EXT_W'({PCNT_W{1'b1}}))
			return '1;
		else
			return ext[PCNT_W-1:0];
	endfunction

endpackage

// ===== design/arp_reply_responder_tracker.sv =====
// Top level: ARP reply responder tracker with responder table and result register.
//
// Takes one parsed ARP item per beat and returns exactly one result beat for it.
// An item sits in an input register, where the table search,
// update and pick are worked out together; the result then lands in the output
// register. Throughput is one item per clock as long as the result side keeps up,
// and a stalled result holds the item in the input register until the output
// register frees. The responder table holds TABLE_ENTRIES MAC/count pairs; a
// count of zero marks a free entry, so a clear request empties the table with no
// sweep. Replies (opcode 2) from the local IP are ignored. Replies from any other
// IP refresh the last good MAC unless they carry the attacker MAC; those from the
// probe IP also update the table. The pick (first used entry not holding the
// attacker MAC) and good_mac show the state after the item's own update.
// Configuration is written through cfg_wen, cfg_addr and cfg_wdata and should
// only change while no item is in flight.
module arp_reply_responder_tracker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write port
	input  logic                                   cfg_wen,
	input  logic [arp_rrt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [arp_rrt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// input items
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// tdata, low bit up: opcode[15:0], sender_ip[47:16], sender_mac[95:48]
	input  logic [arp_rrt_pkg::IN_DATA_W-1:0]      s_tdata,
	// tuser: req_type
	input  logic                                   s_tuser,
	// result items
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// tdata, low bit up: added_new[0], seen_again[1], dropped_full[2], pick_valid[3],
	// pick_index[6:4], pick_mac[54:7], pick_count[70:55], good_mac[118:71], zero pad[119]
	output logic [arp_rrt_pkg::OUT_DATA_W-1:0]     m_tdata
);

	localparam int N = arp_rrt_pkg::TABLE_ENTRIES;

	// configuration registers
	logic [arp_rrt_pkg::IP_W-1:0]  local_ip_q;
	logic [arp_rrt_pkg::IP_W-1:0]  probe_ip_q;
	arp_rrt_pkg::mac_t             attacker_mac_q;

	// input stage
	logic                          valid_s1;
	logic                          req_s1;
	logic [arp_rrt_pkg::OP_W-1:0]  opcode_s1;
	logic [arp_rrt_pkg::IP_W-1:0]  sip_s1;
	arp_rrt_pkg::mac_t             smac_s1;

	// table and last good MAC
	arp_rrt_pkg::mac_t             entry_mac_q   [N];
	arp_rrt_pkg::count_t           entry_count_q [N];
	arp_rrt_pkg::mac_t             good_mac_q;

	// result register
	logic                                  out_valid_q;
	logic [arp_rrt_pkg::OUT_DATA_W-1:0]    out_data_q;

	logic advance;

	// search / update signals
	logic                 is_reply, take_good, track, clr;
	logic                 hit_found, free_found;
	logic [N-1:0]         hit_sel, free_sel;
	logic                 added, seen, dropped;
	arp_rrt_pkg::count_t  count_nxt  [N];
	logic [N-1:0]         mac_wr;
	logic [N-1:0]         used_nxt, not_att_nxt;
	arp_rrt_pkg::mac_t    good_nxt;

	// pick
	logic                                 pick_valid;
	logic [arp_rrt_pkg::PIDX_W-1:0]       pick_index;
	arp_rrt_pkg::mac_t                    pick_mac;
	logic [arp_rrt_pkg::PCNT_W-1:0]       pick_count;

	// s1 moves into the result register whenever that is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q     <= '0;
			probe_ip_q     <= '0;
			attacker_mac_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				arp_rrt_pkg::CFG_LOCAL_IP:     local_ip_q     <= cfg_wdata[arp_rrt_pkg::IP_W-1:0];
				arp_rrt_pkg::CFG_PROBE_IP:     probe_ip_q     <= cfg_wdata[arp_rrt_pkg::IP_W-1:0];
				arp_rrt_pkg::CFG_ATTACKER_MAC: attacker_mac_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1    <= s_tuser;
			opcode_s1 <= s_tdata[15:0];
			sip_s1    <= s_tdata[47:16];
			smac_s1   <= s_tdata[95:48];
		end
	end

	// classify the item
	always_comb begin
		clr       = (req_s1 == arp_rrt_pkg::REQ_CLEAR);
		is_reply  = !clr && (opcode_s1 == arp_rrt_pkg::OPCODE_REPLY) && (sip_s1 != local_ip_q);
		take_good = is_reply && (smac_s1 != attacker_mac_q);
		track     = is_reply && (sip_s1 == probe_ip_q);
		good_nxt  = take_good ? smac_s1 : good_mac_q;
	end

	// first matching used entry and first free entry
	always_comb begin
		hit_found  = 1'b0;
		free_found = 1'b0;
		hit_sel    = '0;
		free_sel   = '0;
		for (int i = 0; i < N; i++) begin
			if (entry_count_q[i] != '0) begin
				if (!hit_found && entry_mac_q[i] == smac_s1) begin
					hit_sel[i] = 1'b1;
					hit_found  = 1'b1;
				end
			end else if (!free_found) begin
				free_sel[i] = 1'b1;
				free_found  = 1'b1;
			end
		end
		seen    = track && hit_found;
		added   = track && !hit_found && free_found;
		dropped = track && !hit_found && !free_found;
	end

	// next table contents; the attacker compare of a freshly written entry reuses
	// the sender MAC compare
	always_comb begin
		for (int i = 0; i < N; i++) begin
			mac_wr[i]    = added && free_sel[i];
			count_nxt[i] = entry_count_q[i];
			if (clr)
				count_nxt[i] = '0;
			else if (mac_wr[i])
				count_nxt[i] = arp_rrt_pkg::COUNT_ONE;
			else if (seen && hit_sel[i] && entry_count_q[i] != arp_rrt_pkg::COUNT_MAX)
				count_nxt[i] = entry_count_q[i] + arp_rrt_pkg::COUNT_ONE;
			used_nxt[i]    = (count_nxt[i] != '0);
			not_att_nxt[i] = mac_wr[i] ? (smac_s1 != attacker_mac_q)
			                           : (entry_mac_q[i] != attacker_mac_q);
		end
	end

	// pick the first used non-attacker entry after the update
	always_comb begin
		pick_valid = 1'b0;
		pick_index = '0;
		pick_mac   = '0;
		pick_count = '0;
		for (int i = 0; i < N; i++) begin
			if (!pick_valid && used_nxt[i] && not_att_nxt[i]) begin
				pick_valid = 1'b1;
				pick_index = arp_rrt_pkg::PIDX_W'(i);
				pick_mac   = mac_wr[i] ? smac_s1 : entry_mac_q[i];
				pick_count = arp_rrt_pkg::show_count(count_nxt[i]);
			end
		end
	end

	// table counts and last good MAC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++)
				entry_count_q[i] <= '0;
			good_mac_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < N; i++)
				entry_count_q[i] <= count_nxt[i];
			good_mac_q <= good_nxt;
		end
	end

	// table MACs: payload only, written when an entry is claimed
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (advance && mac_wr[i])
				entry_mac_q[i] <= smac_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= {1'b0, good_nxt, pick_count, pick_mac, pick_index,
			               pick_valid, dropped, seen, added};
	end

endmodule

// ===== design/arp_rrt_checker.sv =====
// Port-level checker for the ARP reply responder tracker, with its bind.
module arp_rrt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [arp_rrt_pkg::OUT_DATA_W-1:0]  m_tdata
);

	// at most one of added / seen / dropped per beat
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[2:0]))
		else $error("more than one table outcome in a result beat");

	// no pick means all pick fields are zero
	a_no_pick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[3]) |-> (m_tdata[70:4] == '0))
		else $error("pick fields non-zero without a pick");

	// a picked entry is in use and lies inside the table
	a_pick_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3]) |->
			(m_tdata[70:55] != '0) && (m_tdata[6:4] < 3'(arp_rrt_pkg::TABLE_ENTRIES)))
		else $error("pick points at a free or out-of-range entry");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result beat changed while stalled");

endmodule

bind arp_reply_responder_tracker arp_rrt_checker u_arp_rrt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== sim/arp_reply_responder_tracker_test.sv =====
// Self-checking testbench for the ARP reply responder tracker: directed and random beats.
`timescale 1ns / 1ps

module arp_reply_responder_tracker_test;
	import arp_rrt_pkg::*;

	// cycles with no beat and no register write before the run is called hung
	localparam int QUIET_LIMIT = 2000;
	// settle time after the last result, with margin
	localparam int DRAIN_CYCLES = 4;
	localparam int RAND_PHASES = 6;
	localparam int RAND_ITEMS = 190;
	localparam int MAX_PRINTED = 100;
	localparam int POOL_N = 8;

	// settings for the directed phase
	localparam logic [IP_W-1:0] DIR_LOCAL = 32'h0A00_0001;
	localparam logic [IP_W-1:0] DIR_PROBE = 32'h0A00_00FE;
	localparam logic [IP_W-1:0] DIR_OTHER = 32'hC0A8_0117;
	localparam mac_t DIR_ATTACKER = 48'h0200_DEAD_BEEF;

	typedef struct packed {
		logic              req;
		logic [OP_W-1:0]   opcode;
		logic [IP_W-1:0]   sip;
		mac_t              smac;
	} arp_item_t;

	typedef struct packed {
		logic              added;
		logic              seen;
		logic              dropped;
		logic              pvalid;
		logic [PIDX_W-1:0] pidx;
		mac_t              pmac;
		logic [PCNT_W-1:0] pcnt;
		mac_t              good;
	} verdict_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  cfg_wen = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = REQ_OBSERVE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	arp_reply_responder_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Shadow of the block: its registers and responder table
	// ---------------------------------------------------------------
	logic [IP_W-1:0] my_local = '0;
	logic [IP_W-1:0] my_probe = '0;
	mac_t            my_attacker = '0;
	mac_t            tbl_mac [TABLE_ENTRIES];
	count_t          tbl_cnt [TABLE_ENTRIES];
	mac_t            last_good = '0;

	arp_item_t arp_q[$];      // items waiting to be driven
	verdict_t  verdict_q[$];  // results owed by the block, oldest first
	arp_item_t cur_item;      // item currently on the input bus
	int        idle_pct = 29; // chance in a hundred of a gap or a stall
	int        errors = 0;
	int        quiet = 0;
	mac_t      mac_pool [POOL_N];

	initial begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_cnt[i] = '0;
			tbl_mac[i] = '0;
		end
	end

	// Apply one item to the shadow table and work out the result beat it owes.
	function automatic verdict_t tracker_step(arp_item_t it);
		verdict_t    v;
		int          hit;
		int          free_slot;
		int          i;
		logic [63:0] wide;
		v = '0;
		hit = -1;
		free_slot = -1;
		if (it.req == REQ_CLEAR) begin
			// a clear only frees entries; the last good MAC survives it
			for (i = 0; i < TABLE_ENTRIES; i++)
				tbl_cnt[i] = '0;
		end else if (it.opcode == OPCODE_REPLY && it.sip != my_local) begin
			if (it.smac != my_attacker)
				last_good = it.smac;
			if (it.sip == my_probe) begin
				for (i = 0; i < TABLE_ENTRIES; i++) begin
					if (tbl_cnt[i] != '0) begin
						if (hit < 0 && tbl_mac[i] == it.smac)
							hit = i;
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				if (hit >= 0) begin
					// saturating count, but still flagged as seen
					if (tbl_cnt[hit] != COUNT_MAX)
						tbl_cnt[hit] = tbl_cnt[hit] + 1'b1;
					v.seen = 1'b1;
				end else if (free_slot >= 0) begin
					tbl_mac[free_slot] = it.smac;
					tbl_cnt[free_slot] = COUNT_ONE;
					v.added = 1'b1;
				end else begin
					v.dropped = 1'b1;
				end
			end
		end
		// first used entry not holding the attacker MAC, after the update
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			if (!v.pvalid && tbl_cnt[i] != '0 && tbl_mac[i] != my_attacker) begin
				v.pvalid = 1'b1;
				v.pidx = PIDX_W'(i);
				v.pmac = tbl_mac[i];
				wide = 64'(tbl_cnt[i]);
				v.pcnt = (wide > 64'hFFFF) ? '1 : PCNT_W'(wide);
			end
		end
		v.good = last_good;
		return v;
	endfunction

	// ---------------------------------------------------------------
	// Reporting
	// ---------------------------------------------------------------
	task automatic note_mismatch(input string msg);
		if (errors < MAX_PRINTED)
			$display("%0t mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// ---------------------------------------------------------------
	// Input driver: one beat per handshake, random gaps
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			// beat taken at this edge: predict its result now, in order
			if (s_tvalid && s_tready)
				verdict_q.push_back(tracker_step(cur_item));
			if (!s_tvalid || s_tready) begin
				if (arp_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					cur_item = arp_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_item.smac, cur_item.sip, cur_item.opcode};
					s_tuser <= cur_item.req;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= idle_pct);
	end

	// ---------------------------------------------------------------
	// Result monitor
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_mon
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				note_mismatch("result beat with nothing expected");
			end else begin
				want = verdict_q.pop_front();
				check_field("added_new", m_tdata[0], want.added);
				check_field("seen_again", m_tdata[1], want.seen);
				check_field("dropped_full", m_tdata[2], want.dropped);
				check_field("pick_valid", m_tdata[3], want.pvalid);
				check_field("pick_index", m_tdata[6:4], want.pidx);
				check_field("pick_mac", m_tdata[54:7], want.pmac);
				check_field("pick_count", m_tdata[70:55], want.pcnt);
				check_field("good_mac", m_tdata[118:71], want.good);
			end
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: too long with no traffic at all
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("** arp_reply_responder_tracker: FAILED **");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	function automatic arp_item_t mk(input logic req, input logic [OP_W-1:0] op,
			input logic [IP_W-1:0] sip, input mac_t smac);
		arp_item_t it;
		it.req = req;
		it.opcode = op;
		it.sip = sip;
		it.smac = smac;
		return it;
	endfunction

	function automatic mac_t rand_mac();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// register write: only ever called with nothing in flight
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_LOCAL_IP: my_local = val[IP_W-1:0];
			CFG_PROBE_IP: my_probe = val[IP_W-1:0];
			CFG_ATTACKER_MAC: my_attacker = val[MAC_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic setup(input logic [IP_W-1:0] lip, input logic [IP_W-1:0] pip,
			input mac_t amac);
		write_reg(CFG_LOCAL_IP, CFG_DATA_W'(lip));
		write_reg(CFG_PROBE_IP, CFG_DATA_W'(pip));
		write_reg(CFG_ATTACKER_MAC, CFG_DATA_W'(amac));
		// small MAC pool so the table fills, matches and overflows; slot 0 is the attacker
		mac_pool[0] = amac;
		for (int i = 1; i < POOL_N; i++)
			mac_pool[i] = rand_mac();
		@(negedge clk);
	endtask

	// wait until every item is sent and every result is back
	task automatic settle();
		while (arp_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly well-formed replies around the probe IP, some noise and clears
	function automatic arp_item_t rand_item();
		int          r;
		int          w;
		logic [IP_W-1:0] sip;
		mac_t        smac;
		r = $urandom_range(0, 99);
		if (r < 3)
			return mk(REQ_CLEAR, OP_W'($urandom), 32'($urandom), rand_mac());
		if (r < 13)
			return mk(REQ_OBSERVE, OP_W'($urandom), 32'($urandom), rand_mac());
		w = $urandom_range(0, 99);
		if (w < 60)
			sip = my_probe;
		else if (w < 75)
			sip = my_local;
		else if (w < 80)
			sip = $urandom_range(0, 1) ? '1 : '0;
		else
			sip = 32'($urandom);
		if ($urandom_range(0, 19) == 0)
			smac = rand_mac();
		else
			smac = mac_pool[$urandom_range(0, POOL_N - 1)];
		return mk(REQ_OBSERVE, OPCODE_REPLY, sip, smac);
	endfunction

	initial begin
		logic [IP_W-1:0] lip;
		mac_t m1, m2, m3, m4, m5;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: filters, fill, match, overflow, clear, field extremes
		setup(DIR_LOCAL, DIR_PROBE, DIR_ATTACKER);
		m1 = 48'h0011_2233_4455;
		m2 = 48'h0011_2233_4466;
		m3 = 48'h8000_0000_0001;
		m4 = 48'h0000_0000_0001;
		m5 = 48'h7FFF_FFFF_FFFE;
		arp_q.push_back(mk(REQ_OBSERVE, 16'd1, DIR_PROBE, m1));         // request, ignored
		arp_q.push_back(mk(REQ_OBSERVE, '1, DIR_PROBE, '1));            // odd opcode, ignored
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_LOCAL, m1));  // own reply
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_OTHER, m1));  // good MAC only
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_OTHER, DIR_ATTACKER));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, DIR_ATTACKER)); // no pick
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, m1));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, m1));  // seen again
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, m2));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, m3));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, m4));  // table now full
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, m5));  // dropped
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, '1));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, '0));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, m2));  // hit on full table
		arp_q.push_back(mk(REQ_CLEAR, '1, '1, '1));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, m5));  // refill entry 0
		arp_q.push_back(mk(REQ_OBSERVE, '0, '0, '0));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, '0, m2));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, '1, m3));
		arp_q.push_back(mk(REQ_CLEAR, '0, '0, '0));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, DIR_ATTACKER));
		arp_q.push_back(mk(REQ_OBSERVE, OPCODE_REPLY, DIR_PROBE, m4));  // pick skips attacker
		settle();

		// random phases over a spread of settings, extremes first
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: setup('0, '1, '0);
				1: setup('1, '0, '1);
				3: begin
					// probe equals local: table never touched
					lip = 32'($urandom);
					setup(lip, lip, rand_mac());
				end
				default: setup(32'($urandom), 32'($urandom), rand_mac());
			endcase
			// one phase runs flat out on both sides
			idle_pct = (p == 2) ? 0 : 29;
			for (int i = 0; i < RAND_ITEMS; i++)
				arp_q.push_back(rand_item());
			settle();
		end

		if (errors == 0 && verdict_q.size() == 0)
			$display("** arp_reply_responder_tracker: PASSED **");
		else
			$display("** arp_reply_responder_tracker: FAILED **");
		$finish;
	end

endmodule

// ===== arp_reply_responder_tracker.f =====
design/arp_rrt_pkg.sv
design/arp_reply_responder_tracker.sv
design/arp_rrt_checker.sv
sim/arp_reply_responder_tracker_test.sv
